@@ hw/rtl/sfod_pkg.sv @@
// Shared types, widths and codes for the six-face orientation detector.
// No dependencies; imported by sfod_eval and the top level.
package sfod_pkg;

  // Field widths
  localparam int ACC_W      = 16;
  localparam int THR_W      = 13;
  localparam int FACE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Working width of the compare arithmetic: holds +-(32768 + 16384)
  localparam int CALC_W     = 18;

  // Default fixed-point scaling
  localparam int FRACTION_BITS_DEF = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FACE = 2'd1;

  // Face codes
  localparam logic [FACE_W-1:0] FACE_UNKNOWN = 3'd0;
  localparam logic [FACE_W-1:0] FACE_ZP      = 3'd1;
  localparam logic [FACE_W-1:0] FACE_XP      = 3'd2;
  localparam logic [FACE_W-1:0] FACE_YP      = 3'd3;
  localparam logic [FACE_W-1:0] FACE_YN      = 3'd4;
  localparam logic [FACE_W-1:0] FACE_XN      = 3'd5;
  localparam logic [FACE_W-1:0] FACE_ZN      = 3'd6;
  localparam int                FACE_COUNT   = 6;

  // Expected direction of one axis
  typedef enum logic [1:0] {
    AX_ZERO = 2'b00,
    AX_POS  = 2'b01,
    AX_NEG  = 2'b10
  } axis_dir_t;

  typedef struct packed {
    axis_dir_t x;
    axis_dir_t y;
    axis_dir_t z;
  } face_vec_t;

  // Unit vector of a face; the unknown face points nowhere
  function automatic face_vec_t face_vec(logic [FACE_W-1:0] f);
    face_vec_t v;
    v.x = AX_ZERO;
    v.y = AX_ZERO;
    v.z = AX_ZERO;
    unique case (f)
      FACE_ZP: v.z = AX_POS;
      FACE_XP: v.x = AX_POS;
      FACE_YP: v.y = AX_POS;
      FACE_YN: v.y = AX_NEG;
      FACE_XN: v.x = AX_NEG;
      FACE_ZN: v.z = AX_NEG;
      default: v.x = AX_ZERO;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/six_face_orientation_detector_top.sv @@
// Six-face orientation detector, top level. A request passes through the
// input register, then the result register, before its result is valid.
// Throughput: one request per cycle while out_stall does not hold a result;
// the face register feeds back through the compare logic in sfod_eval.
// Reset (rst_n low, synchronous): pipeline empty, face unknown, threshold
// 0.4 g. Depends on sfod_pkg and sfod_eval.
module six_face_orientation_detector_top
  import sfod_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input requests
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ACC_W-1:0] in_accel_x,
  input  logic signed [ACC_W-1:0] in_accel_y,
  input  logic signed [ACC_W-1:0] in_accel_z,
  // results
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [FACE_W-1:0]       out_face,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [THR_W-1:0] THRESHOLD_RESET =
    THR_W'((2 * (1 << FRACTION_BITS) + 2) / 5);

  logic                    s1_valid_r, s1_valid_nxt;
  logic signed [ACC_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [FACE_W-1:0]       out_face_r;
  logic [FACE_W-1:0]       face_r, face_nxt;
  logic [THR_W-1:0]        threshold_r, threshold_nxt;
  logic [FACE_W-1:0]       eval_face;
  logic                    in_take, s1_adv, out_free;

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Hold the request in the input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x_r <= in_accel_x;
      s1_y_r <= in_accel_y;
      s1_z_r <= in_accel_z;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  sfod_eval #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_eval (
    .face_i    (face_r),
    .accel_x   (s1_x_r),
    .accel_y   (s1_y_r),
    .accel_z   (s1_z_r),
    .threshold (threshold_r),
    .face_o    (eval_face)
  );

  // Advance the face state and config registers
  always_comb begin
    face_nxt      = face_r;
    threshold_nxt = threshold_r;
    if (s1_adv) begin
      face_nxt = eval_face;
    end
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold_nxt = cfg_wdata[THR_W-1:0];
        REG_START_FACE: face_nxt = (cfg_wdata[FACE_W-1:0] <= FACE_ZN) ?
                                   cfg_wdata[FACE_W-1:0] : FACE_UNKNOWN;
        default:        threshold_nxt = threshold_r;
      endcase
    end
  end

  // Drop the result once taken, load a new one on advance
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_face_r <= eval_face;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      face_r      <= FACE_UNKNOWN;
      threshold_r <= THRESHOLD_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      face_r      <= face_nxt;
      threshold_r <= threshold_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_face  = out_face_r;

endmodule

@@ hw/rtl/sfod_eval.sv @@
// Next-face evaluation: departure test against the current face, then
// the six-face match scan. Pure combinational; depends on sfod_pkg.
module sfod_eval
  import sfod_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic [FACE_W-1:0]       face_i,
  input  logic signed [ACC_W-1:0] accel_x,
  input  logic signed [ACC_W-1:0] accel_y,
  input  logic signed [ACC_W-1:0] accel_z,
  input  logic [THR_W-1:0]        threshold,
  output logic [FACE_W-1:0]       face_o
);

  localparam logic signed [CALC_W-1:0] ONE_G =
    {{(CALC_W-1){1'b0}}, 1'b1} << FRACTION_BITS;

  logic signed [CALC_W-1:0] ax, ay, az, thr, lim;
  face_vec_t                cur_vec, cand_vec;
  logic                     depart;

  // An axis departs from its expected direction
  function automatic logic axis_departs(axis_dir_t d, logic signed [CALC_W-1:0] a,
                                        logic signed [CALC_W-1:0] t);
    logic r;
    case (d)
      AX_POS:  r = a < (ONE_G - t);
      AX_NEG:  r = a > (t - ONE_G);
      default: r = (a < -t) || (a > t);
    endcase
    return r;
  endfunction

  // An axis lies within the match window of its expected direction
  function automatic logic axis_matches(axis_dir_t d, logic signed [CALC_W-1:0] a,
                                        logic signed [CALC_W-1:0] l);
    logic signed [CALC_W-1:0] target;
    logic signed [CALC_W-1:0] diff;
    logic signed [CALC_W-1:0] mag;
    case (d)
      AX_POS:  target = ONE_G;
      AX_NEG:  target = -ONE_G;
      default: target = '0;
    endcase
    diff = target - a;
    mag  = (diff < 0) ? -diff : diff;
    return mag < l;
  endfunction

  // Widen operands to the compare width
  assign ax  = {{(CALC_W-ACC_W){accel_x[ACC_W-1]}}, accel_x};
  assign ay  = {{(CALC_W-ACC_W){accel_y[ACC_W-1]}}, accel_y};
  assign az  = {{(CALC_W-ACC_W){accel_z[ACC_W-1]}}, accel_z};
  assign thr = {{(CALC_W-THR_W){1'b0}}, threshold};
  assign lim = ONE_G - thr;

  // Hysteresis: re-evaluate only when some axis leaves the current face
  assign cur_vec = face_vec(face_i);
  assign depart  = axis_departs(cur_vec.x, ax, thr) ||
                   axis_departs(cur_vec.y, ay, thr) ||
                   axis_departs(cur_vec.z, az, thr);

  // Scan faces in order; the last match wins, no match keeps the face
  always_comb begin
    face_o   = face_i;
    cand_vec = face_vec(FACE_UNKNOWN);
    if (depart) begin
      for (int i = 1; i <= FACE_COUNT; i++) begin
        cand_vec = face_vec(FACE_W'(i));
        if (axis_matches(cand_vec.x, ax, lim) &&
            axis_matches(cand_vec.y, ay, lim) &&
            axis_matches(cand_vec.z, az, lim)) begin
          face_o = FACE_W'(i);
        end
      end
    end
  end

endmodule
